// ----- hdl/masked_yuyv_to_hsv_pixel_unit_macros.svh -----
// assertion macros shared by the pixel unit
`ifndef MASKED_YUYV_TO_HSV_PIXEL_UNIT_MACROS_SVH
`define MASKED_YUYV_TO_HSV_PIXEL_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MXHSV_ASSERT_IMPL(name, ck, rn, a, b) \
  name: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define MXHSV_ASSERT_NEXT(name, ck, rn, a, b) \
  name: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/mxhsv_pkg.sv -----
package mxhsv_pkg;

  localparam int DIV_QW = 8;
  localparam int DIV_NW = 16;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
  } mxhsv_in_t;

  typedef struct packed {
    logic [7:0] hue_first;
    logic [7:0] sat_first;
    logic [7:0] val_first;
    logic [7:0] hue_second;
    logic [7:0] sat_second;
    logic [7:0] val_second;
  } mxhsv_out_t;

  // which channel holds the maximum
  localparam logic [1:0] HUE_OFF_R = 2'd0;
  localparam logic [1:0] HUE_OFF_G = 2'd1;
  localparam logic [1:0] HUE_OFF_B = 2'd2;

  // register indexes
  localparam logic [1:0] REG_CENTER_X    = 2'd0;
  localparam logic [1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [1:0] REG_MASK_RADIUS = 2'd2;

  typedef struct packed {
    logic [DIV_NW-1:0] sat_num;
    logic [DIV_NW-1:0] hue_num;
    logic [7:0]        d;
    logic [7:0]        mx;
    logic              neg;
    logic [1:0]        off;
    logic              grey;
  } mxhsv_pre_t;

  typedef struct packed {
    logic [7:0] mx;
    logic       neg;
    logic [1:0] off;
    logic       grey;
    logic       in_mask;
  } mxhsv_side_t;

endpackage

// ----- hdl/mxhsv_stream_if.sv -----
interface mxhsv_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/mxhsv_front.sv -----
module mxhsv_front (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  logic [7:0]             luma,
  input  logic [7:0]             cb,
  input  logic [7:0]             cr,
  output mxhsv_pkg::mxhsv_pre_t  pre_r
);
  import mxhsv_pkg::*;

  logic signed [8:0]  cbs, crs;
  logic signed [11:0] cbx, crx, ys;
  logic signed [11:0] b_raw, g_raw, r_raw;
  logic [7:0]         r_r, g_r, b_r;
  logic [7:0]         mx, mn;
  logic signed [8:0]  diff;
  logic [8:0]         mag;
  mxhsv_pre_t         pre_nxt;

  function automatic logic [7:0] clamp8(input logic signed [11:0] x);
    if (x >= 12'sd255) begin
      return 8'hff;
    end else if (x <= 12'sd0) begin
      return 8'h00;
    end else begin
      return x[7:0];
    end
  endfunction

  // yuv to rgb, shift-add coefficients
  always_comb begin
    cbs   = $signed({1'b0, cb}) - 9'sd128;
    crs   = $signed({1'b0, cr}) - 9'sd128;
    cbx   = {{3{cbs[8]}}, cbs};
    crx   = {{3{crs[8]}}, crs};
    ys    = $signed({4'b0, luma});
    b_raw = ys + cbx + (cbx >>> 1) + (cbx >>> 2) + (cbx >>> 6);
    g_raw = ys - ((cbx >>> 2) + (cbx >>> 4) + (cbx >>> 5))
               - ((crx >>> 1) + (crx >>> 3) + (crx >>> 4) + (crx >>> 5));
    r_raw = ys + crx + (crx >>> 2) + (crx >>> 3) + (crx >>> 5);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r <= clamp8(r_raw);
      g_r <= clamp8(g_raw);
      b_r <= clamp8(b_raw);
    end
  end

  // max, min and division operands
  always_comb begin
    mx = (r_r > g_r) ? r_r : g_r;
    if (b_r > mx) mx = b_r;
    mn = (r_r < g_r) ? r_r : g_r;
    if (b_r < mn) mn = b_r;
    priority if (r_r == mx) begin
      diff        = $signed({1'b0, g_r}) - $signed({1'b0, b_r});
      pre_nxt.off = HUE_OFF_R;
    end else if (g_r == mx) begin
      diff        = $signed({1'b0, b_r}) - $signed({1'b0, r_r});
      pre_nxt.off = HUE_OFF_G;
    end else begin
      diff        = $signed({1'b0, r_r}) - $signed({1'b0, g_r});
      pre_nxt.off = HUE_OFF_B;
    end
    mag             = diff[8] ? 9'(-diff) : 9'(diff);
    pre_nxt.neg     = diff[8];
    pre_nxt.d       = mx - mn;
    pre_nxt.mx      = mx;
    pre_nxt.grey    = (mx == mn);
    pre_nxt.sat_num = {8'b0, pre_nxt.d} * 16'd255;
    pre_nxt.hue_num = {8'b0, mag[7:0]} * 16'd60;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pre_r <= pre_nxt;
    end
  end
endmodule

// ----- hdl/mxhsv_div.sv -----
module mxhsv_div (
  input  logic                           clk,
  input  logic [mxhsv_pkg::DIV_QW-1:0]   en,
  input  logic [mxhsv_pkg::DIV_NW-1:0]   num,
  input  logic [7:0]                     den,
  output logic [mxhsv_pkg::DIV_QW-1:0]   quo
);
  import mxhsv_pkg::*;

  logic [DIV_NW-1:0] rem_r [DIV_QW];
  logic [7:0]        den_r [DIV_QW];
  logic [DIV_QW-1:0] q_r   [DIV_QW];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    logic [DIV_NW-1:0] rem_in, trial;
    logic [7:0]        den_in;
    logic [DIV_QW-1:0] q_in;
    logic              ge;

    always_comb begin
      rem_in = (k == 0) ? num : rem_r[(k == 0) ? 0 : k - 1];
      den_in = (k == 0) ? den : den_r[(k == 0) ? 0 : k - 1];
      q_in   = (k == 0) ? '0  : q_r[(k == 0) ? 0 : k - 1];
      trial  = DIV_NW'(den_in) << (DIV_QW - 1 - k);
      ge     = (rem_in >= trial);
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? rem_in - trial : rem_in;
        den_r[k] <= den_in;
        q_r[k]   <= q_in | (DIV_QW'(ge) << (DIV_QW - 1 - k));
      end
    end
  end

  assign quo = q_r[DIV_QW-1];
endmodule

// ----- hdl/mxhsv_mask.sv -----
module mxhsv_mask #(
  parameter int FRAME_DIM = 1024
) (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [10:0] col,
  input  logic [9:0]  row,
  input  logic [9:0]  center_x,
  input  logic [9:0]  center_y,
  input  logic [10:0] radius,
  output logic        inside_r
);
  logic signed [12:0] dx, dy;
  logic signed [25:0] dx_sq, dy_sq;
  logic [21:0]        dx2_r, dy2_r, rr_r;
  logic               off_frame_r;

  always_comb begin
    dx    = $signed({2'b0, col}) - $signed({3'b0, center_x});
    dy    = $signed({3'b0, row}) - $signed({3'b0, center_y});
    dx_sq = dx * dx;
    dy_sq = dy * dy;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx2_r       <= dx_sq[21:0];
      dy2_r       <= dy_sq[21:0];
      rr_r        <= radius * radius;
      off_frame_r <= (32'(col) >= FRAME_DIM) || (32'(row) >= FRAME_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      inside_r <= !off_frame_r && ((23'(dx2_r) + 23'(dy2_r)) < 23'(rr_r));
    end
  end
endmodule

// ----- hdl/masked_yuyv_to_hsv_pixel_unit.sv -----
// throughput: one macropixel per cycle while the output is ready; set by the one-bit-per-stage dividers
// being fully pipelined (8 stages) behind 2 conversion stages and 1 output stage
// stalls pass back through a combinational ready chain, so bubbles in the pipe still fill
// reset (rst_n low, synchronous): pipe valid bits cleared, mask centre 0,0,
// mask radius 2047
module masked_yuyv_to_hsv_pixel_unit #(
  parameter int FRAME_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mxhsv_stream_if.sink          in_if,
  mxhsv_stream_if.source        out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import mxhsv_pkg::*;
  `include "masked_yuyv_to_hsv_pixel_unit_macros.svh"

  // stage map: 0 rgb and squares, 1 max/min and mask compare,
  // 2..DIV_QW+1 dividers, last stage hue fix-up and output register
  localparam int DIV0   = 2;
  localparam int NSTAGE = DIV_QW + 3;
  localparam int SOUT   = NSTAGE - 1;

  // config registers
  logic [9:0]  center_x_r, center_y_r;
  logic [10:0] mask_radius_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      mask_radius_r <= 11'd2047;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CENTER_X:    center_x_r    <= pwdata[9:0];
        REG_CENTER_Y:    center_y_r    <= pwdata[9:0];
        REG_MASK_RADIUS: mask_radius_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CENTER_X:    prdata = {22'b0, center_x_r};
      REG_CENTER_Y:    prdata = {22'b0, center_y_r};
      REG_MASK_RADIUS: prdata = {21'b0, mask_radius_r};
      default:         prdata = '0;
    endcase
  end

  // per-stage valid bits and a ready chain that lets bubbles collapse
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE:0]   en;

  always_comb begin
    en[NSTAGE] = out_if.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (en[k]) v_r[k] <= (k == 0) ? in_if.valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // conversion front end, one per pixel, shared chroma
  mxhsv_pre_t pre0_r, pre1_r;

  mxhsv_front u_front0 (
    .clk  (clk),
    .en   (en[1:0]),
    .luma (in_if.data.luma_first),
    .cb   (in_if.data.chroma_blue),
    .cr   (in_if.data.chroma_red),
    .pre_r(pre0_r)
  );

  mxhsv_front u_front1 (
    .clk  (clk),
    .en   (en[1:0]),
    .luma (in_if.data.luma_second),
    .cb   (in_if.data.chroma_blue),
    .cr   (in_if.data.chroma_red),
    .pre_r(pre1_r)
  );

  // circular mask, second pixel one column further
  logic in0_r, in1_r;

  mxhsv_mask #(.FRAME_DIM(FRAME_DIM)) u_mask0 (
    .clk     (clk),
    .en      (en[1:0]),
    .col     ({1'b0, in_if.data.pixel_column}),
    .row     (in_if.data.pixel_row),
    .center_x(center_x_r),
    .center_y(center_y_r),
    .radius  (mask_radius_r),
    .inside_r(in0_r)
  );

  mxhsv_mask #(.FRAME_DIM(FRAME_DIM)) u_mask1 (
    .clk     (clk),
    .en      (en[1:0]),
    .col     ({1'b0, in_if.data.pixel_column} + 11'd1),
    .row     (in_if.data.pixel_row),
    .center_x(center_x_r),
    .center_y(center_y_r),
    .radius  (mask_radius_r),
    .inside_r(in1_r)
  );

  // saturation = d*255/max, hue part = |diff|*60/d
  logic [DIV_QW-1:0] sat0_q, sat1_q, hue0_q, hue1_q;

  mxhsv_div u_sdiv0 (.clk(clk), .en(en[SOUT-1:DIV0]), .num(pre0_r.sat_num),
                     .den(pre0_r.mx), .quo(sat0_q));
  mxhsv_div u_sdiv1 (.clk(clk), .en(en[SOUT-1:DIV0]), .num(pre1_r.sat_num),
                     .den(pre1_r.mx), .quo(sat1_q));
  mxhsv_div u_hdiv0 (.clk(clk), .en(en[SOUT-1:DIV0]), .num(pre0_r.hue_num),
                     .den(pre0_r.d), .quo(hue0_q));
  mxhsv_div u_hdiv1 (.clk(clk), .en(en[SOUT-1:DIV0]), .num(pre1_r.hue_num),
                     .den(pre1_r.d), .quo(hue1_q));

  // side data riding alongside the dividers
  mxhsv_side_t side0_r [DIV0:SOUT-1];
  mxhsv_side_t side1_r [DIV0:SOUT-1];

  always_ff @(posedge clk) begin
    for (int k = DIV0; k < SOUT; k++) begin
      if (en[k]) begin
        if (k == DIV0) begin
          side0_r[k] <= '{mx: pre0_r.mx, neg: pre0_r.neg, off: pre0_r.off,
                          grey: pre0_r.grey, in_mask: in0_r};
          side1_r[k] <= '{mx: pre1_r.mx, neg: pre1_r.neg, off: pre1_r.off,
                          grey: pre1_r.grey, in_mask: in1_r};
        end else begin
          side0_r[k] <= side0_r[(k == DIV0) ? DIV0 : k - 1];
          side1_r[k] <= side1_r[(k == DIV0) ? DIV0 : k - 1];
        end
      end
    end
  end

  // hue offset, sign, wrap and halve
  function automatic logic [7:0] hue_fix(input mxhsv_side_t sd, input logic [7:0] q);
    logic signed [9:0] base, hs;
    unique case (sd.off)
      HUE_OFF_R: base = 10'sd0;
      HUE_OFF_G: base = 10'sd120;
      HUE_OFF_B: base = 10'sd240;
      default:   base = 10'sd0;
    endcase
    hs = sd.neg ? base - $signed({2'b0, q}) : base + $signed({2'b0, q});
    if (hs < 0) hs = hs + 10'sd360;
    return hs[8:1];
  endfunction

  mxhsv_out_t out_r, out_nxt;

  always_comb begin
    out_nxt = '0;
    if (side0_r[SOUT-1].in_mask) begin
      out_nxt.val_first = side0_r[SOUT-1].mx;
      if (!side0_r[SOUT-1].grey) begin
        out_nxt.hue_first = hue_fix(side0_r[SOUT-1], hue0_q);
        out_nxt.sat_first = sat0_q;
      end
    end
    if (side1_r[SOUT-1].in_mask) begin
      out_nxt.val_second = side1_r[SOUT-1].mx;
      if (!side1_r[SOUT-1].grey) begin
        out_nxt.hue_second = hue_fix(side1_r[SOUT-1], hue1_q);
        out_nxt.sat_second = sat1_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SOUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = v_r[SOUT];
  assign out_if.data  = out_r;

  // checks
  `MXHSV_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_if.valid && in_if.ready, v_r[0])
  `MXHSV_ASSERT_NEXT(a_stall_keeps, clk, rst_n, v_r[DIV0] && !en[DIV0], v_r[DIV0])
  `MXHSV_ASSERT_IMPL(a_hue_range, clk, rst_n, out_if.valid, out_if.data.hue_first <= 8'd179)
  `MXHSV_ASSERT_IMPL(a_black_grey, clk, rst_n, out_if.valid && out_if.data.val_second == 8'd0, out_if.data.sat_second == 8'd0 && out_if.data.hue_second == 8'd0)
endmodule

// ----- tb/sv/masked_yuyv_to_hsv_pixel_unit_tb.sv -----
`timescale 1ns / 100ps

module masked_yuyv_to_hsv_pixel_unit_tb;
  import mxhsv_pkg::*;

  localparam int FRAME_DIM = 1024;
  localparam int LATENCY = 11;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // config port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mxhsv_stream_if #(.payload_t(mxhsv_in_t))  pix_in ();
  mxhsv_stream_if #(.payload_t(mxhsv_out_t)) hsv_out ();

  masked_yuyv_to_hsv_pixel_unit #(.FRAME_DIM(FRAME_DIM)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (pix_in.sink),
    .out_if  (hsv_out.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor's copy of the mask registers
  int unsigned mask_cx = 0;
  int unsigned mask_cy = 0;
  int unsigned mask_r  = 2047;

  mxhsv_in_t  pixel_queue[$];
  mxhsv_out_t hsv_expected[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int hold_cycles = 0;
  int idle_count = 0;

  function automatic int shr(int x, int n);
    return x >>> n;  // arithmetic on signed int
  endfunction

  function automatic int clip8(int x);
    if (x >= 255) return 255;
    if (x <= 0) return 0;
    return x;
  endfunction

  function automatic bit in_circle(longint col, longint row);
    longint dx, dy;
    if (col >= FRAME_DIM || row >= FRAME_DIM) return 1'b0;
    dx = col - longint'(mask_cx);
    dy = row - longint'(mask_cy);
    return dx * dx + dy * dy < longint'(mask_r) * longint'(mask_r);
  endfunction

  // hsv of one pixel, packed as {hue, sat, val}
  function automatic logic [23:0] pixel_hsv(int y, int cb, int cr);
    int b, g, r, mx, mn, d, h, s;
    b = clip8(y + cb + shr(cb, 1) + shr(cb, 2) + shr(cb, 6));
    g = clip8(y - (shr(cb, 2) + shr(cb, 4) + shr(cb, 5))
                - (shr(cr, 1) + shr(cr, 3) + shr(cr, 4) + shr(cr, 5)));
    r = clip8(y + cr + shr(cr, 2) + shr(cr, 3) + shr(cr, 5));
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    d = mx - mn;
    if (d != 0) begin
      s = d * 255 / mx;
      if (r == mx) h = (g - b) * 60 / d;
      else if (g == mx) h = 120 + (b - r) * 60 / d;
      else h = 240 + (r - g) * 60 / d;
      if (h < 0) h += 360;
    end else begin
      s = 0;
      h = 0;
    end
    return {8'(h / 2), 8'(s), 8'(mx)};
  endfunction

  function automatic mxhsv_out_t macropixel_hsv(mxhsv_in_t p);
    mxhsv_out_t o;
    int cb, cr;
    cb = int'(p.chroma_blue) - 128;
    cr = int'(p.chroma_red) - 128;
    o = '0;
    if (in_circle(p.pixel_column, p.pixel_row))
      {o.hue_first, o.sat_first, o.val_first} = pixel_hsv(p.luma_first, cb, cr);
    if (in_circle(longint'(p.pixel_column) + 1, p.pixel_row))
      {o.hue_second, o.sat_second, o.val_second} = pixel_hsv(p.luma_second, cb, cr);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // driver: pops pending requests, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_in.valid <= 1'b0;
    end else if (pix_in.valid && !pix_in.ready) begin
      // hold the current request
    end else begin
      if (pix_in.valid) hsv_expected.push_back(macropixel_hsv(pix_in.data));
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_in.data  <= pixel_queue.pop_front();
        pix_in.valid <= 1'b1;
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (recv_hold && hold_cycles < 200) begin
      hold_cycles <= hold_cycles + 1;
      hsv_out.ready <= 1'b0;
    end else begin
      if (recv_hold) recv_hold <= 1'b0;
      hsv_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result request with the oldest expectation
  always @(posedge clk) begin
    mxhsv_out_t want, got;
    if (rst_n && hsv_out.valid && hsv_out.ready) begin
      got = hsv_out.data;
      if (hsv_expected.size() == 0) begin
        report_mismatch("unexpected result request", 1, 0);
      end else begin
        want = hsv_expected.pop_front();
        if (got.hue_first != want.hue_first) report_mismatch("hue_first", got.hue_first, want.hue_first);
        if (got.sat_first != want.sat_first) report_mismatch("sat_first", got.sat_first, want.sat_first);
        if (got.val_first != want.val_first) report_mismatch("val_first", got.val_first, want.val_first);
        if (got.hue_second != want.hue_second)
          report_mismatch("hue_second", got.hue_second, want.hue_second);
        if (got.sat_second != want.sat_second)
          report_mismatch("sat_second", got.sat_second, want.sat_second);
        if (got.val_second != want.val_second)
          report_mismatch("val_second", got.val_second, want.val_second);
      end
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (hsv_out.valid && hsv_out.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X:    mask_cx = value & 32'h3FF;
      REG_CENTER_Y:    mask_cy = value & 32'h3FF;
      REG_MASK_RADIUS: mask_r  = value & 32'h7FF;
      default: ;
    endcase
  endtask

  // wait until all requests were taken and all results came back
  task automatic drain();
    while (pixel_queue.size() != 0 || pix_in.valid || hsv_expected.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic mxhsv_in_t rand_pixel();
    mxhsv_in_t p;
    p.luma_first   = $urandom;
    p.chroma_blue  = $urandom;
    p.luma_second  = $urandom;
    p.chroma_red   = $urandom;
    p.pixel_column = $urandom;
    p.pixel_row    = $urandom;
    return p;
  endfunction

  task automatic random_phase(int n);
    mxhsv_in_t p;
    repeat (n) begin
      p = rand_pixel();
      // mostly near the centre so masking edges get hit
      if ($urandom_range(3) != 0) begin
        p.pixel_column = 10'(mask_cx + $urandom_range(80) - 40);
        p.pixel_row    = 10'(mask_cy + $urandom_range(80) - 40);
      end
      pixel_queue.push_back(p);
    end
  endtask

  initial begin
    mxhsv_in_t p;
    pix_in.valid  = 1'b0;
    pix_in.data   = '0;
    hsv_out.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, grey pixels, last column, odd column
    pixel_queue.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0});
    pixel_queue.push_back('{8'd255, 8'd255, 8'd255, 8'd255, 10'd1022, 10'd1023});
    pixel_queue.push_back('{8'd128, 8'd128, 8'd77, 8'd128, 10'd4, 10'd4});
    pixel_queue.push_back('{8'd255, 8'd0, 8'd0, 8'd255, 10'd1023, 10'd0});
    pixel_queue.push_back('{8'd60, 8'd255, 8'd200, 8'd0, 10'd7, 10'd3});
    pixel_queue.push_back('{8'd100, 8'd0, 8'd150, 8'd0, 10'd100, 10'd9});
    pixel_queue.push_back('{8'd90, 8'd200, 8'd30, 8'd60, 10'd511, 10'd512});
    pixel_queue.push_back('{8'd180, 8'd40, 8'd20, 8'd220, 10'd2, 10'd1023});
    drain();

    // tight mask around a centre, points on its edges, and radius 0
    reg_write(REG_CENTER_X, 32'd500);
    reg_write(REG_CENTER_Y, 32'd300);
    reg_write(REG_MASK_RADIUS, 32'd20);
    pixel_queue.push_back('{8'd200, 8'd30, 8'd100, 8'd210, 10'd480, 10'd300});
    pixel_queue.push_back('{8'd200, 8'd30, 8'd100, 8'd210, 10'd519, 10'd300});
    pixel_queue.push_back('{8'd200, 8'd30, 8'd100, 8'd210, 10'd500, 10'd320});
    pixel_queue.push_back('{8'd200, 8'd30, 8'd100, 8'd210, 10'd500, 10'd319});
    drain();
    reg_write(REG_MASK_RADIUS, 32'd0);
    pixel_queue.push_back('{8'd200, 8'd30, 8'd100, 8'd210, 10'd500, 10'd300});
    drain();

    // phase 1: sender idles 33, receiver 65
    send_idle_pct = 33;
    recv_idle_pct = 65;
    reg_write(REG_CENTER_X, 32'd1023);
    reg_write(REG_CENTER_Y, 32'd1023);
    reg_write(REG_MASK_RADIUS, 32'd2047);
    random_phase(350);
    drain();

    // phase 2: the other way round, with a long receiver hold-off
    send_idle_pct = 65;
    recv_idle_pct = 33;
    reg_write(REG_CENTER_X, 32'd512);
    reg_write(REG_CENTER_Y, 32'd512);
    reg_write(REG_MASK_RADIUS, 32'd300);
    recv_hold = 1'b1;
    random_phase(350);
    drain();

    // phase 3: no idling, random registers, then full radius
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(REG_CENTER_X, $urandom);
    reg_write(REG_CENTER_Y, $urandom);
    reg_write(REG_MASK_RADIUS, $urandom);
    random_phase(200);
    drain();
    reg_write(REG_MASK_RADIUS, 32'd2047);
    random_phase(200);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mxhsv_pkg.sv
hdl/mxhsv_stream_if.sv
hdl/mxhsv_front.sv
hdl/mxhsv_div.sv
hdl/mxhsv_mask.sv
hdl/masked_yuyv_to_hsv_pixel_unit.sv
tb/sv/masked_yuyv_to_hsv_pixel_unit_tb.sv
